### rtl/core/tlsf_pkg.sv
// shared types, constants and helper functions of the size-class bitmap engine
`default_nettype none
package tlsf_pkg;

    // field widths
    localparam int SIZE_W      = 32;
    localparam int OP_W        = 2;
    localparam int CLASS_W     = 8;
    localparam int ROW_IDX_W   = 5;
    localparam int COL_W       = 3;
    localparam int SUB_LEVELS  = 8;
    localparam int BAND_W      = 2;
    localparam int SHIFT_W     = 5;
    localparam int SCALE_W     = 10;
    localparam int LS_W        = 4;

    // default number of first-level rows
    localparam int FIRST_LEVELS_DEF = 24;

    // band granule shifts: 4-byte, 4K and 4M
    localparam int GRAIN_SHIFT     = 2;
    localparam int MID_BAND_SHIFT  = 12;
    localparam int HIGH_BAND_SHIFT = 22;

    // class of the last sublevel of the last row of a band, low six bits
    localparam logic [5:0] BAND_LAST_CLASS = 6'h3F;

    // band codes
    localparam logic [BAND_W-1:0] BAND_LOW  = 2'd0;
    localparam logic [BAND_W-1:0] BAND_MID  = 2'd1;
    localparam logic [BAND_W-1:0] BAND_HIGH = 2'd2;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_SEARCH     = 2'd0,
        OP_MARK_FULL  = 2'd1,
        OP_MARK_EMPTY = 2'd2
    } op_t;

    // size mapping result handed to the bitmap unit
    typedef struct packed {
        logic [CLASS_W-1:0] class_idx;   // class of the given size
        logic [CLASS_W-1:0] round_class; // class of the rounded size
        logic [SIZE_W-1:0]  round_size;  // size rounded up to its class bound
        logic               overflow;    // roundup passed 32 bits
    } cls_info_t;

    // one result word
    typedef struct packed {
        logic               found;
        logic [CLASS_W-1:0] class_index;
        logic [SIZE_W-1:0]  rounded_size;
    } res_t;

    // position of the highest set bit plus one, zero for no bit
    function automatic logic [LS_W-1:0] top_bit10(input logic [SCALE_W-1:0] v);
        logic [LS_W-1:0] n;
        n = '0;
        for (int i = 0; i < SCALE_W; i++) begin
            if (v[i]) begin
                n = LS_W'(i + 1);
            end
        end
        return n;
    endfunction

    // index of the lowest set bit, zero for no bit
    function automatic logic [COL_W-1:0] low_bit8(input logic [SUB_LEVELS-1:0] v);
        logic [COL_W-1:0] n;
        n = '0;
        for (int i = SUB_LEVELS - 1; i >= 0; i--) begin
            if (v[i]) begin
                n = COL_W'(i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

### rtl/core/two_level_size_class_bitmap_search.sv
// top level of the two-level segregated-fit class and bitmap engine
//
//   channel  | direction | tdata                                  | tuser
//   ---------+-----------+----------------------------------------+-----------------
//   s_       | in        | [31:0] req_size                        | [1:0] op
//   m_       | out       | [7:0] class_index, [39:8] rounded_size | [0] found
//
// one word per cycle while m_ does not stall; each word passes the input register, then
// the result register; the mapping, search and mask update sit in the one logic stage
// between them, so a mark is seen by the next word.
// reset clears both masks and both stage valids.
// a stall on m_ holds both stages; s_tready falls only when both are full.
`default_nettype none
module two_level_size_class_bitmap_search #(
    parameter int FIRST_LEVELS = tlsf_pkg::FIRST_LEVELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] req_size
    input  wire logic [1:0]  s_tuser,   // [1:0] op
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [39:0] m_tdata,   // [7:0] class_index, [39:8] rounded_size
    output      logic [0:0]  m_tuser    // [0] found
);

    logic                         in_valid_reg;
    logic                         in_valid_next;
    tlsf_pkg::op_t                in_op_reg;
    tlsf_pkg::op_t                in_op_next;
    logic [tlsf_pkg::SIZE_W-1:0]  in_size_reg;
    logic [tlsf_pkg::SIZE_W-1:0]  in_size_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    tlsf_pkg::res_t               out_res_reg;
    tlsf_pkg::res_t               out_res_next;

    logic                         out_ready;
    logic                         s_take;
    logic                         advance;
    tlsf_pkg::cls_info_t          info;
    tlsf_pkg::res_t               res;

    // flow control
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_take    = s_tvalid && s_tready;
    assign advance   = in_valid_reg && out_ready;

    // size mapping
    tlsf_class_map u_class_map (
        .req_size (in_size_reg),
        .info     (info)
    );

    // masks, search and marks
    tlsf_bitmap #(
        .FIRST_LEVELS (FIRST_LEVELS)
    ) u_bitmap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .upd_en   (advance),
        .op       (in_op_reg),
        .req_size (in_size_reg),
        .info     (info),
        .res      (res)
    );

    // next values of both stages
    always_comb begin
        in_op_next     = in_op_reg;
        in_size_next   = in_size_reg;
        out_res_next   = out_res_reg;
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
            in_op_next    = tlsf_pkg::op_t'(s_tuser);
            in_size_next  = s_tdata;
        end else if (out_ready) begin
            in_valid_next = 1'b0;
        end
        if (out_ready) begin
            out_valid_next = in_valid_reg;
        end
        if (advance) begin
            out_res_next = res;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_op_reg   <= in_op_next;
        in_size_reg <= in_size_next;
        out_res_reg <= out_res_next;
    end

    // result word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.rounded_size, out_res_reg.class_index};
    assign m_tuser  = out_res_reg.found;

`ifndef SYNTHESIS
    // a mark always reports success in the following cycle
    a_mark_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_op_reg == tlsf_pkg::OP_MARK_FULL ||
                     in_op_reg == tlsf_pkg::OP_MARK_EMPTY))
        |=> (m_tvalid && m_tuser[0]))
        else $error("mark word did not report found");

    // a not-found result carries class zero
    a_miss_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == 8'd0))
        else $error("not-found result with nonzero class");

    // a held input word is not dropped during an output stall
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_ready) |=> in_valid_reg)
        else $error("input stage lost a word during a stall");
`endif

endmodule
`default_nettype wire

### rtl/core/tlsf_class_map.sv
// size to class mapping and roundup to the next class bound
`default_nettype none
module tlsf_class_map (
    input  wire logic [tlsf_pkg::SIZE_W-1:0] req_size,
    output tlsf_pkg::cls_info_t              info
);

    logic [tlsf_pkg::BAND_W-1:0]  band;
    logic [tlsf_pkg::SCALE_W-1:0] scaled;
    logic [tlsf_pkg::SHIFT_W-1:0] grain;
    logic [tlsf_pkg::LS_W-1:0]    ls;
    logic [2:0]                   local_lv;
    logic [tlsf_pkg::COL_W-1:0]   sub_lv;
    logic [2:0]                   extra;
    logic [tlsf_pkg::SHIFT_W-1:0] sh;
    logic [tlsf_pkg::SIZE_W-1:0]  low_mask;
    logic                         need_up;
    logic [tlsf_pkg::SIZE_W:0]    up_wide;
    logic [tlsf_pkg::CLASS_W-1:0] cls;

    // band select and scaled size
    always_comb begin
        if (|req_size[31:22]) begin
            band   = tlsf_pkg::BAND_HIGH;
            scaled = req_size[31:22];
            grain  = tlsf_pkg::SHIFT_W'(tlsf_pkg::HIGH_BAND_SHIFT);
        end else if (|req_size[21:12]) begin
            band   = tlsf_pkg::BAND_MID;
            scaled = req_size[21:12];
            grain  = tlsf_pkg::SHIFT_W'(tlsf_pkg::MID_BAND_SHIFT);
        end else begin
            band   = tlsf_pkg::BAND_LOW;
            scaled = req_size[11:2];
            grain  = tlsf_pkg::SHIFT_W'(tlsf_pkg::GRAIN_SHIFT);
        end
    end

    // row and column within the band
    always_comb begin
        ls = tlsf_pkg::top_bit10(scaled);
        if (ls > 4'd3) begin
            local_lv = 3'(ls - 4'd3);
            extra    = 3'(ls - 4'd4);
            sub_lv   = 3'(scaled >> extra);
        end else begin
            local_lv = 3'd0;
            extra    = 3'd0;
            sub_lv   = scaled[2:0];
        end
        cls = {band, local_lv, sub_lv};
    end

    // roundup: fill the bits below the class granule and add one
    always_comb begin
        sh       = grain + tlsf_pkg::SHIFT_W'(extra);
        low_mask = ~(32'hFFFF_FFFF << sh);
        need_up  = |(req_size & low_mask);
        if (need_up) begin
            up_wide = {1'b0, req_size | low_mask} + 33'd1;
        end else begin
            up_wide = {1'b0, req_size};
        end
    end

    // rounded class: next class, or past the unused first class of the next band
    always_comb begin
        info.class_idx  = cls;
        info.round_size = up_wide[tlsf_pkg::SIZE_W-1:0];
        info.overflow   = up_wide[tlsf_pkg::SIZE_W];
        if (!need_up) begin
            info.round_class = cls;
        end else if (cls[5:0] == tlsf_pkg::BAND_LAST_CLASS) begin
            info.round_class = cls + 8'd2;
        end else begin
            info.round_class = cls + 8'd1;
        end
    end

endmodule
`default_nettype wire

### rtl/core/tlsf_bitmap.sv
// first-level and sublevel masks with the fit search and mark updates
`default_nettype none
module tlsf_bitmap #(
    parameter int FIRST_LEVELS = tlsf_pkg::FIRST_LEVELS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         upd_en,
    input  wire tlsf_pkg::op_t                op,
    input  wire logic [tlsf_pkg::SIZE_W-1:0]  req_size,
    input  wire tlsf_pkg::cls_info_t          info,
    output tlsf_pkg::res_t                    res
);

    logic [FIRST_LEVELS-1:0]          fl_mask_reg;
    logic [FIRST_LEVELS-1:0]          fl_mask_next;
    logic [tlsf_pkg::SUB_LEVELS-1:0]  sl_mask_reg  [FIRST_LEVELS];
    logic [tlsf_pkg::SUB_LEVELS-1:0]  sl_mask_next [FIRST_LEVELS];

    logic [tlsf_pkg::ROW_IDX_W-1:0]   rf;
    logic [tlsf_pkg::COL_W-1:0]       rs;
    logic [tlsf_pkg::ROW_IDX_W-1:0]   mark_row;
    logic [tlsf_pkg::SUB_LEVELS-1:0]  mark_bit;
    logic [tlsf_pkg::SUB_LEVELS-1:0]  cur_row;
    logic [tlsf_pkg::SUB_LEVELS-1:0]  cur_hit;
    logic [FIRST_LEVELS-1:0]          higher;
    logic [FIRST_LEVELS-1:0]          first_hi;
    logic [tlsf_pkg::SUB_LEVELS-1:0]  hi_row;
    logic [tlsf_pkg::ROW_IDX_W-1:0]   hi_idx;

    assign rf       = info.round_class[tlsf_pkg::CLASS_W-1:tlsf_pkg::COL_W];
    assign rs       = info.round_class[tlsf_pkg::COL_W-1:0];
    assign mark_row = info.class_idx[tlsf_pkg::CLASS_W-1:tlsf_pkg::COL_W];
    assign mark_bit = tlsf_pkg::SUB_LEVELS'(1) << info.class_idx[tlsf_pkg::COL_W-1:0];

    // row of the rounded class, and the first non-empty row above it
    always_comb begin
        cur_row = '0;
        higher  = '0;
        for (int f = 0; f < FIRST_LEVELS; f++) begin
            if (tlsf_pkg::ROW_IDX_W'(f) == rf) begin
                cur_row = cur_row | sl_mask_reg[f];
            end
            higher[f] = fl_mask_reg[f] && (tlsf_pkg::ROW_IDX_W'(f) > rf);
        end
        cur_hit  = cur_row & (8'hFF << rs);
        first_hi = higher & (~higher + FIRST_LEVELS'(1));
        hi_row   = '0;
        hi_idx   = '0;
        for (int f = 0; f < FIRST_LEVELS; f++) begin
            if (first_hi[f]) begin
                hi_row = hi_row | sl_mask_reg[f];
                hi_idx = hi_idx | tlsf_pkg::ROW_IDX_W'(f);
            end
        end
    end

    // result word
    always_comb begin
        res = '0;
        case (op)
            tlsf_pkg::OP_SEARCH: begin
                if (!info.overflow) begin
                    res.rounded_size = info.round_size;
                    if (|cur_hit) begin
                        res.found       = 1'b1;
                        res.class_index = {rf, tlsf_pkg::low_bit8(cur_hit)};
                    end else if (|hi_row) begin
                        res.found       = 1'b1;
                        res.class_index = {hi_idx, tlsf_pkg::low_bit8(hi_row)};
                    end
                end
            end
            tlsf_pkg::OP_MARK_FULL, tlsf_pkg::OP_MARK_EMPTY: begin
                res.found        = 1'b1;
                res.class_index  = info.class_idx;
                res.rounded_size = req_size;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    // mark updates, one row lane each
    always_comb begin
        fl_mask_next = fl_mask_reg;
        for (int f = 0; f < FIRST_LEVELS; f++) begin
            sl_mask_next[f] = sl_mask_reg[f];
            if (upd_en && (tlsf_pkg::ROW_IDX_W'(f) == mark_row)) begin
                if (op == tlsf_pkg::OP_MARK_FULL) begin
                    sl_mask_next[f] = sl_mask_reg[f] | mark_bit;
                    fl_mask_next[f] = 1'b1;
                end else if (op == tlsf_pkg::OP_MARK_EMPTY) begin
                    sl_mask_next[f] = sl_mask_reg[f] & ~mark_bit;
                    if (sl_mask_next[f] == '0) begin
                        fl_mask_next[f] = 1'b0;
                    end
                end
            end
        end
    end

    // mask registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fl_mask_reg <= '0;
            for (int f = 0; f < FIRST_LEVELS; f++) begin
                sl_mask_reg[f] <= '0;
            end
        end else begin
            fl_mask_reg <= fl_mask_next;
            for (int f = 0; f < FIRST_LEVELS; f++) begin
                sl_mask_reg[f] <= sl_mask_next[f];
            end
        end
    end

endmodule
`default_nettype wire
